// File: hdl/rnd_pkg.sv
// Package with the shared constants and types of the rank normalizer.
`timescale 1ns / 1ps

package rnd_pkg;

   localparam int MAX_COUNT = 64;
   localparam int VAL_W     = 32;
   localparam int RANK_W    = 6;
   localparam int POS_W     = 6;
   localparam int STATUS_W  = 2;
   localparam int IDX_W     = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);

   localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DUP      = 2'd1,
      STATUS_TOO_MANY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_DRAIN = 3'b010,
      ST_OUT   = 3'b100
   } state_type;

   // A value travelling down the chain. It stays live to the chain end so that
   // its duplicate flag can be collected there; spent marks that it has been stored.
   typedef struct packed {
      logic                    live;
      logic                    spent;
      logic signed [VAL_W-1:0] value;
      logic [RANK_W-1:0]       mine;
      logic                    dup;
   } token_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

// File: hdl/rnd_cell.sv
// One chain cell: holds one stored value and its count of smaller values.
`timescale 1ns / 1ps

module rnd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  rnd_pkg::cell_ctl_type       ctl_i,
   input  rnd_pkg::token_type          tok_i,
   output rnd_pkg::token_type          tok_o,
   input  logic [rnd_pkg::RANK_W-1:0]  count_next_i,
   output logic [rnd_pkg::RANK_W-1:0]  count_o
);

   rnd_pkg::token_type              tok_ff, tok_in;
   logic                            valid_ff, valid_in;
   logic signed [rnd_pkg::VAL_W-1:0] value_ff, value_in;
   logic [rnd_pkg::RANK_W-1:0]      count_ff, count_in;

   always_comb begin
      tok_in   = tok_i;
      valid_in = valid_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (ctl_i.clear) begin
         valid_in = 1'b0;
      end else if (ctl_i.shift) begin
         count_in = count_next_i;
      end else if (tok_i.live && !tok_i.spent) begin
         if (valid_ff) begin
            if (value_ff < tok_i.value) begin
               tok_in.mine = tok_i.mine + 1'b1;
            end else if (value_ff > tok_i.value) begin
               count_in = count_ff + 1'b1;
            end else begin
               tok_in.dup = 1'b1;
            end
         end else begin
            // First free cell takes the value; the word keeps going as spent.
            valid_in    = 1'b1;
            value_in    = tok_i.value;
            count_in    = tok_i.mine;
            tok_in.spent = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         tok_ff.live <= tok_in.live;
      end
      tok_ff.spent <= tok_in.spent;
      tok_ff.value <= tok_in.value;
      tok_ff.mine  <= tok_in.mine;
      tok_ff.dup   <= tok_in.dup;
      value_ff     <= value_in;
      count_ff     <= count_in;
   end

   assign tok_o   = tok_ff;
   assign count_o = count_ff;

endmodule

// File: hdl/rank_normalizer_with_dup_check.sv
// Top level of the rank normalizer: input control, cell chain and result sequencing.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_value, req_last_item
//   rsp      out        rsp_valid, rsp_stall, rsp_rank, rsp_position, rsp_status,
//                       rsp_min_position, rsp_max_position, rsp_last_result
//
// While loading, one word is taken every cycle; each value walks the cell chain, one cell
// a cycle, comparing with every stored value on its way. After the last word the chain
// drains, then the results are shifted out one per cycle while rsp_stall is low;
// req_stall stays high until the final result is taken.
// Reset is synchronous and clears the control state; it needs no clearing pass.
// A stalled result holds, since the chain shifts only when a result is taken.
`timescale 1ns / 1ps

module rank_normalizer_with_dup_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [rnd_pkg::VAL_W-1:0] req_value,
   input  logic                           req_last_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rnd_pkg::RANK_W-1:0]     rsp_rank,
   output logic [rnd_pkg::POS_W-1:0]      rsp_position,
   output logic [rnd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rnd_pkg::POS_W-1:0]      rsp_min_position,
   output logic [rnd_pkg::POS_W-1:0]      rsp_max_position,
   output logic                           rsp_last_result
);

   rnd_pkg::state_type               state_ff, state_in;
   logic [rnd_pkg::CNT_W-1:0]        loaded_ff, loaded_in;
   logic [rnd_pkg::CNT_W-1:0]        drain_ff, drain_in;
   logic [rnd_pkg::IDX_W-1:0]        out_idx_ff, out_idx_in;
   logic                             dup_ff, dup_in;
   logic                             overflow_ff, overflow_in;
   logic signed [rnd_pkg::VAL_W-1:0] smallest_ff, smallest_in;
   logic signed [rnd_pkg::VAL_W-1:0] largest_ff, largest_in;
   logic [rnd_pkg::POS_W-1:0]        min_pos_ff, min_pos_in;
   logic [rnd_pkg::POS_W-1:0]        max_pos_ff, max_pos_in;
   rnd_pkg::token_type               head_ff, head_in;

   rnd_pkg::token_type               tok_link [0:rnd_pkg::MAX_COUNT];
   logic [rnd_pkg::RANK_W-1:0]       cnt_link [0:rnd_pkg::MAX_COUNT];
   rnd_pkg::cell_ctl_type            cell_ctl;

   logic                             req_accept, rsp_accept;
   logic                             has_room, is_error, is_final;
   logic [rnd_pkg::POS_W-1:0]        load_pos;
   rnd_pkg::status_type              status;

   assign req_stall  = (state_ff != rnd_pkg::ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == rnd_pkg::ST_OUT);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign has_room = (loaded_ff < rnd_pkg::CNT_W'(rnd_pkg::MAX_COUNT));
   assign load_pos = rnd_pkg::POS_W'(loaded_ff[rnd_pkg::IDX_W-1:0]);
   assign is_error = overflow_ff || dup_ff;
   assign is_final = is_error ||
                     ((rnd_pkg::CNT_W'(out_idx_ff) + 1'b1) == loaded_ff);

   always_comb begin
      if (overflow_ff) begin
         status = rnd_pkg::STATUS_TOO_MANY;
      end else if (dup_ff) begin
         status = rnd_pkg::STATUS_DUP;
      end else begin
         status = rnd_pkg::STATUS_OK;
      end
   end

   assign rsp_status       = status;
   assign rsp_rank         = is_error ? '0 : cnt_link[0];
   assign rsp_position     = is_error ? '0 : rnd_pkg::POS_W'(out_idx_ff);
   assign rsp_min_position = (is_final && !is_error) ? min_pos_ff : '0;
   assign rsp_max_position = (is_final && !is_error) ? max_pos_ff : '0;
   assign rsp_last_result  = is_final;

   assign cell_ctl.shift = rsp_accept && !is_final;
   assign cell_ctl.clear = rsp_accept && is_final;

   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      drain_in    = drain_ff;
      out_idx_in  = out_idx_ff;
      overflow_in = overflow_ff;
      smallest_in = smallest_ff;
      largest_in  = largest_ff;
      min_pos_in  = min_pos_ff;
      max_pos_in  = max_pos_ff;
      dup_in      = dup_ff;

      head_in       = head_ff;
      head_in.live  = 1'b0;
      head_in.spent = 1'b0;
      head_in.value = req_value;
      head_in.mine  = '0;
      head_in.dup   = 1'b0;

      // Duplicate flags are collected where the words leave the chain.
      if (tok_link[rnd_pkg::MAX_COUNT].live && tok_link[rnd_pkg::MAX_COUNT].dup) begin
         dup_in = 1'b1;
      end

      case (state_ff)
         rnd_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (has_room) begin
                  head_in.live = 1'b1;
                  loaded_in    = loaded_ff + 1'b1;
                  if (req_value < smallest_ff) begin
                     smallest_in = req_value;
                     min_pos_in  = load_pos;
                  end
                  if (req_value > largest_ff) begin
                     largest_in = req_value;
                     max_pos_in = load_pos;
                  end
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_last_item) begin
                  drain_in = '0;
                  state_in = rnd_pkg::ST_DRAIN;
               end
            end
         end
         rnd_pkg::ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == rnd_pkg::CNT_W'(rnd_pkg::MAX_COUNT)) begin
               out_idx_in = '0;
               state_in   = rnd_pkg::ST_OUT;
            end
         end
         rnd_pkg::ST_OUT: begin
            if (rsp_accept) begin
               if (is_final) begin
                  state_in    = rnd_pkg::ST_LOAD;
                  loaded_in   = '0;
                  overflow_in = 1'b0;
                  dup_in      = 1'b0;
                  smallest_in = rnd_pkg::INT_MAX;
                  largest_in  = rnd_pkg::INT_MIN;
                  min_pos_in  = '0;
                  max_pos_in  = '0;
               end else begin
                  out_idx_in = out_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = rnd_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rnd_pkg::ST_LOAD;
         loaded_ff    <= '0;
         drain_ff     <= '0;
         out_idx_ff   <= '0;
         dup_ff       <= 1'b0;
         overflow_ff  <= 1'b0;
         smallest_ff  <= rnd_pkg::INT_MAX;
         largest_ff   <= rnd_pkg::INT_MIN;
         min_pos_ff   <= '0;
         max_pos_ff   <= '0;
         head_ff.live <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         drain_ff     <= drain_in;
         out_idx_ff   <= out_idx_in;
         dup_ff       <= dup_in;
         overflow_ff  <= overflow_in;
         smallest_ff  <= smallest_in;
         largest_ff   <= largest_in;
         min_pos_ff   <= min_pos_in;
         max_pos_ff   <= max_pos_in;
         head_ff.live <= head_in.live;
      end
      head_ff.spent <= head_in.spent;
      head_ff.value <= head_in.value;
      head_ff.mine  <= head_in.mine;
      head_ff.dup   <= head_in.dup;
   end

   assign tok_link[0]                  = head_ff;
   assign cnt_link[rnd_pkg::MAX_COUNT] = '0;

   for (genvar i = 0; i < rnd_pkg::MAX_COUNT; i++) begin : g_cell
      rnd_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl_i        (cell_ctl),
         .tok_i        (tok_link[i]),
         .tok_o        (tok_link[i+1]),
         .count_next_i (cnt_link[i+1]),
         .count_o      (cnt_link[i])
      );
   end

   // Results are only shown once no word can still be in the chain.
   a_no_token_at_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !tok_link[rnd_pkg::MAX_COUNT].live)
      else $error("word still in the chain while results are shown");

   a_overflow_sticks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !has_room) |=> overflow_ff)
      else $error("too-many condition was not recorded");

   a_error_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status != rnd_pkg::STATUS_OK)) |-> (rsp_last_result && rsp_rank == '0))
      else $error("error result is not a single final result");

   a_run_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_result) |=> (loaded_ff == '0 && !dup_ff && !overflow_ff))
      else $error("state not cleared after the final result");

endmodule

// File: test/rnd_rank_checker.sv
// Checker for the rank normalizer: predicts each result word and compares it with the block.
`timescale 1ns / 1ps

module rnd_rank_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [rnd_pkg::VAL_W-1:0]  req_value,
   input  logic                              req_last_item,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [rnd_pkg::RANK_W-1:0]        rsp_rank,
   input  logic [rnd_pkg::POS_W-1:0]         rsp_position,
   input  logic [rnd_pkg::STATUS_W-1:0]      rsp_status,
   input  logic [rnd_pkg::POS_W-1:0]         rsp_min_position,
   input  logic [rnd_pkg::POS_W-1:0]         rsp_max_position,
   input  logic                              rsp_last_result,
   output int                                failure_count,
   output int                                outstanding
);

   typedef struct packed {
      logic [rnd_pkg::RANK_W-1:0] rank;
      logic [rnd_pkg::POS_W-1:0]  position;
      rnd_pkg::status_type        status;
      logic [rnd_pkg::POS_W-1:0]  min_position;
      logic [rnd_pkg::POS_W-1:0]  max_position;
      logic                       last_result;
   } ranked_word_type;

   ranked_word_type ranks_due[$];

   logic signed [rnd_pkg::VAL_W-1:0] held_values[rnd_pkg::MAX_COUNT];
   logic [rnd_pkg::RANK_W-1:0]       below_count[rnd_pkg::MAX_COUNT];
   int unsigned                      loaded;
   logic                             dup_flag;
   logic                             over_flag;
   logic signed [rnd_pkg::VAL_W-1:0] low_value;
   logic signed [rnd_pkg::VAL_W-1:0] high_value;
   logic [rnd_pkg::POS_W-1:0]        low_pos;
   logic [rnd_pkg::POS_W-1:0]        high_pos;
   int                               failures = 0;

   initial outstanding = 0;
   assign failure_count = failures;

   task automatic clear_state();
      for (int i = 0; i < rnd_pkg::MAX_COUNT; i++) begin
         below_count[i] = '0;
      end
      loaded     = 0;
      dup_flag   = 1'b0;
      over_flag  = 1'b0;
      low_value  = rnd_pkg::INT_MAX;
      high_value = rnd_pkg::INT_MIN;
      low_pos    = '0;
      high_pos   = '0;
   endtask

   function automatic ranked_word_type make_word(input int unsigned rank,
                                                 input int unsigned pos,
                                                 input rnd_pkg::status_type status,
                                                 input int unsigned minp,
                                                 input int unsigned maxp,
                                                 input logic last_result);
      ranked_word_type w;
      w.rank         = rank[rnd_pkg::RANK_W-1:0];
      w.position     = pos[rnd_pkg::POS_W-1:0];
      w.status       = status;
      w.min_position = minp[rnd_pkg::POS_W-1:0];
      w.max_position = maxp[rnd_pkg::POS_W-1:0];
      w.last_result  = last_result;
      return w;
   endfunction

   // Takes one loaded word into the predicted state; on the last word of a set
   // it queues the whole set of expected result words.
   task automatic absorb_word(input logic signed [rnd_pkg::VAL_W-1:0] v, input logic last);
      logic [rnd_pkg::RANK_W-1:0] mine;
      if (loaded >= rnd_pkg::MAX_COUNT) begin
         over_flag = 1'b1;
      end else begin
         mine = '0;
         for (int j = 0; j < loaded; j++) begin
            if (held_values[j] < v) begin
               mine = mine + 1'b1;
            end else if (held_values[j] > v) begin
               below_count[j] = below_count[j] + 1'b1;
            end else begin
               dup_flag = 1'b1;
            end
         end
         held_values[loaded] = v;
         below_count[loaded] = mine;
         // Strict compares, so a tie keeps the earlier position.
         if (v < low_value) begin
            low_value = v;
            low_pos   = loaded[rnd_pkg::POS_W-1:0];
         end
         if (v > high_value) begin
            high_value = v;
            high_pos   = loaded[rnd_pkg::POS_W-1:0];
         end
         loaded = loaded + 1;
      end
      if (last) begin
         if (over_flag) begin
            ranks_due.push_back(make_word(0, 0, rnd_pkg::STATUS_TOO_MANY, 0, 0, 1'b1));
         end else if (dup_flag) begin
            ranks_due.push_back(make_word(0, 0, rnd_pkg::STATUS_DUP, 0, 0, 1'b1));
         end else begin
            for (int i = 0; i < loaded; i++) begin
               if (i == loaded - 1) begin
                  ranks_due.push_back(make_word(below_count[i], i, rnd_pkg::STATUS_OK,
                                                low_pos, high_pos, 1'b1));
               end else begin
                  ranks_due.push_back(make_word(below_count[i], i, rnd_pkg::STATUS_OK,
                                                0, 0, 1'b0));
               end
            end
         end
         clear_state();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
      end
   endtask

   always @(posedge clock) begin
      ranked_word_type want;
      if (reset) begin
         clear_state();
         ranks_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            absorb_word(req_value, req_last_item);
         end
         if (rsp_valid && !rsp_stall) begin
            if (ranks_due.size() == 0) begin
               report_mismatch($sformatf("result word with none expected, position %0d status %0d",
                                         rsp_position, rsp_status));
            end else begin
               want = ranks_due.pop_front();
               check_field("rank", want.rank, rsp_rank);
               check_field("position", want.position, rsp_position);
               check_field("status", want.status, rsp_status);
               check_field("min_position", want.min_position, rsp_min_position);
               check_field("max_position", want.max_position, rsp_max_position);
               check_field("last_result", want.last_result, rsp_last_result);
            end
         end
      end
      outstanding <= ranks_due.size();
   end

endmodule

// File: test/rank_normalizer_with_dup_check_tb.sv
// Testbench top for the rank normalizer: clock, reset, word stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module rank_normalizer_with_dup_check_tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD   = 400;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [rnd_pkg::VAL_W-1:0] req_value = '0;
   logic                             req_last_item = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [rnd_pkg::RANK_W-1:0]       rsp_rank;
   logic [rnd_pkg::POS_W-1:0]        rsp_position;
   logic [rnd_pkg::STATUS_W-1:0]     rsp_status;
   logic [rnd_pkg::POS_W-1:0]        rsp_min_position;
   logic [rnd_pkg::POS_W-1:0]        rsp_max_position;
   logic                             rsp_last_result;

   int failure_count;
   int outstanding;
   int cycle_count = 0;
   int burst_left = 0;
   logic hold_request = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;
   int rx_cycles = 0;

   rank_normalizer_with_dup_check dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rank         (rsp_rank),
      .rsp_position     (rsp_position),
      .rsp_status       (rsp_status),
      .rsp_min_position (rsp_min_position),
      .rsp_max_position (rsp_max_position),
      .rsp_last_result  (rsp_last_result)
   );

   rnd_rank_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rank         (rsp_rank),
      .rsp_position     (rsp_position),
      .rsp_status       (rsp_status),
      .rsp_min_position (rsp_min_position),
      .rsp_max_position (rsp_max_position),
      .rsp_last_result  (rsp_last_result),
      .failure_count    (failure_count),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("rank_normalizer_with_dup_check: mismatch");
         $finish;
      end
   end

   // Receiver: one long hold-off when asked for, otherwise a stall pattern that
   // steps through four densities in turn, including stretches with no stall.
   always @(posedge clock) begin
      rx_cycles <= rx_cycles + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         case ((rx_cycles / 150) % 4)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Offers one word and returns at the edge where it is taken.
   task automatic send_word(input logic signed [rnd_pkg::VAL_W-1:0] v, input logic last,
                            input bit gappy);
      int gap;
      if (gappy) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_values(input logic signed [rnd_pkg::VAL_W-1:0] vals[$], input bit gappy);
      foreach (vals[i]) begin
         send_word(vals[i], i == vals.size() - 1, gappy);
      end
   endtask

   // Draws a value not yet in the set, often close to the extremes of the range.
   function automatic logic signed [rnd_pkg::VAL_W-1:0] fresh_value(
         ref logic signed [rnd_pkg::VAL_W-1:0] taken[$]);
      logic signed [rnd_pkg::VAL_W-1:0] v;
      bit clash;
      do begin
         case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = rnd_pkg::INT_MIN + $urandom_range(0, 15);
            2:       v = rnd_pkg::INT_MAX - $urandom_range(0, 15);
            default: v = $signed($urandom_range(0, 64)) - 32;
         endcase
         clash = 1'b0;
         foreach (taken[i]) begin
            if (taken[i] == v) clash = 1'b1;
         end
      end while (clash);
      return v;
   endfunction

   task automatic send_set(input int n, input bit with_dup, input bit gappy);
      logic signed [rnd_pkg::VAL_W-1:0] vals[$];
      int dup_at;
      int stored_limit;
      for (int i = 0; i < n; i++) begin
         vals.push_back(fresh_value(vals));
      end
      // The copy lands among the words that are actually stored.
      if (with_dup && n >= 2) begin
         stored_limit = (n > rnd_pkg::MAX_COUNT) ? rnd_pkg::MAX_COUNT : n;
         dup_at = $urandom_range(1, stored_limit - 1);
         vals[dup_at] = vals[$urandom_range(0, dup_at - 1)];
      end
      send_values(vals, gappy);
   endtask

   initial begin
      int random_words;
      int set_size;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_values('{rnd_pkg::INT_MIN}, 1'b0);
      send_values('{rnd_pkg::INT_MAX, rnd_pkg::INT_MIN, 32'sd0, -32'sd1, 32'sd1,
                    32'sh5555_5555, 32'shAAAA_AAAA}, 1'b0);
      send_values('{32'sd5, -32'sd3, 32'sd5}, 1'b1);
      send_values('{rnd_pkg::INT_MAX, rnd_pkg::INT_MAX}, 1'b1);
      send_values('{32'sd3, 32'sd2, 32'sd1, 32'sd0}, 1'b1);

      random_words = 0;
      while (random_words < 10) begin
         set_size = $urandom_range(1, 6);
         send_set(set_size, $urandom_range(0, 2) == 0, $urandom_range(0, 2) != 0);
         random_words += set_size;
      end

      // A full set while the receiver holds off, so the block backs up onto its input.
      hold_request <= 1'b1;
      send_set(rnd_pkg::MAX_COUNT, 1'b0, 1'b0);
      // Too many words with a duplicate among the stored ones: the overflow wins.
      send_set(rnd_pkg::MAX_COUNT + $urandom_range(1, 2), 1'b1, 1'b1);
      send_set(3, 1'b0, 1'b1);
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (rnd_pkg::MAX_COUNT + 20) @(posedge clock);

      if (failure_count == 0) begin
         $display("rank_normalizer_with_dup_check: match");
      end else begin
         $display("rank_normalizer_with_dup_check: mismatch");
      end
      $finish;
   end

endmodule
